### src/bsp_pkg.sv
// Shared constants, register indexes, types and the sync pattern function for the bit slicer / sync packer.
// No dependencies.
`default_nettype none

package bsp_pkg;

  // Bits per packed word (8..16).
  localparam int WORD_BITS = 16;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 16;
  localparam int HIST_W   = 16;
  localparam int FILL_W   = 4;
  localparam int CFG_W    = 16;

  // Highest bit position of a word, which is also the fill count of the last bit.
  localparam logic [FILL_W-1:0] TOP_POS = FILL_W'(WORD_BITS - 1);

  localparam logic [HIST_W-1:0] SYNC_RESET = 16'hFACE;

  // Configuration register indexes.
  localparam logic REG_HUNT_EN   = 1'b0;
  localparam logic REG_SYNC_WORD = 1'b1;

  // What one processed bit produces.
  typedef struct packed {
    logic             emit;
    logic [OUT_W-1:0] word;
  } bsp_res_t;

  // Pattern as seen in the history: byte-swapped for words wider than 8 bits.
  function automatic logic [HIST_W-1:0] cmp_pattern(input logic [HIST_W-1:0] p);
    logic [HIST_W-1:0] r;
    if (WORD_BITS > 8) begin
      r = {p[7:0], p[15:8]};
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/bsp_core.sv
// Slicer, sync hunt and word packer state; one bit per step.
// Depends on bsp_pkg.
`default_nettype none

module bsp_core
  import bsp_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       hunt_en,
  input  wire logic [HIST_W-1:0]          sync_word,
  output bsp_res_t                        res
);

  logic              locked_r, locked_nxt;
  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic [OUT_W-1:0]  partial_r, partial_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic              bit_val;
  logic              hunting;
  logic              last;
  logic [HIST_W-1:0] hist_shift;
  logic [FILL_W-1:0] pos;
  logic [OUT_W-1:0]  word_set;

  // greater than zero: nonzero with sign clear
  assign bit_val    = ~sample[SAMPLE_W-1] & (|sample);
  assign hunting    = ~locked_r & hunt_en;
  assign hist_shift = {hist_r[HIST_W-2:0], bit_val};
  assign pos        = TOP_POS - fill_r;
  assign last       = (fill_r == TOP_POS);

  always_comb begin
    word_set = partial_r;
    word_set[pos] = partial_r[pos] | bit_val;
  end

  assign res.emit = ~hunting & last;
  assign res.word = word_set;

  always_comb begin
    locked_nxt  = locked_r;
    hist_nxt    = hist_r;
    partial_nxt = partial_r;
    fill_nxt    = fill_r;
    if (step) begin
      if (hunting) begin
        hist_nxt = hist_shift;
        // lock bit goes to history only
        if (hist_shift == cmp_pattern(sync_word)) begin
          locked_nxt = 1'b1;
        end
      end else if (last) begin
        partial_nxt = '0;
        fill_nxt    = '0;
      end else begin
        partial_nxt = word_set;
        fill_nxt    = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r  <= 1'b0;
      hist_r    <= '0;
      partial_r <= '0;
      fill_r    <= '0;
    end else begin
      locked_r  <= locked_nxt;
      hist_r    <= hist_nxt;
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

### src/bit_slicer_sync_packer.sv
// out_valid rises from the result register, loaded when the input register retires the
// sample that completes a word (input reg feeds result reg).
// Throughput: one sample per cycle; the input register stalls only when a word must
// go out while the result register is full and stalled.
// A result appears only for the sample that completes a word.
// Reset (rst_n low, synchronous): unlocked, history and partial word cleared,
// sync hunt enabled, sync word 0xFACE, both pipeline registers empty.
// Depends on bsp_pkg and bsp_core.
`default_nettype none

module bit_slicer_sync_packer
  import bsp_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // sample channel
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  // packed word channel
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [OUT_W-1:0]           out_packed_word,
  // configuration writes
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data
);

  // Configuration registers
  logic              hunt_en_r;
  logic [HIST_W-1:0] sync_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_en_r   <= 1'b1;
      sync_word_r <= SYNC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUNT_EN:   hunt_en_r   <= cfg_data[0];
        REG_SYNC_WORD: sync_word_r <= cfg_data[HIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_go;
  logic                       in_xfer;
  bsp_res_t                   res;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_word_r;

  // Stage 1 retires its bit unless that bit completes a word and the result
  // register cannot take it this cycle.
  assign s1_go    = s1_valid_r & (~res.emit | ~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_go;
  assign in_xfer  = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_sample;
    end
    if (s1_go && res.emit) begin
      out_word_r <= res.word;
    end
  end

  bsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .sample    (s1_sample_r),
    .hunt_en   (hunt_en_r),
    .sync_word (sync_word_r),
    .res       (res)
  );

  assign out_valid       = out_valid_r;
  assign out_packed_word = out_word_r;

  // Stall only comes from a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // A completed word always lands in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && res.emit) |=> (out_valid_r && out_word_r == $past(res.word)))
    else $error("completed word not registered");

  // A held stage-1 sample is not overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_sample_r)))
    else $error("stage 1 sample lost");

endmodule

`default_nettype wire
